[src/bnc_pkg.sv]
`default_nettype none

package bnc_pkg;

  // default frame limits, handed to the top level parameters
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // register reset values
  localparam logic       RST_MODE_CLOSE = 1'b0;
  localparam logic [2:0] RST_THRESHOLD  = 3'd2;
  localparam logic [10:0] RST_FRAME     = 11'd1024;

  // register indexes (word address)
  typedef enum logic [1:0] {
    REG_MODE_CLOSE   = 2'd0,
    REG_THRESHOLD    = 2'd1,
    REG_FRAME_WIDTH  = 2'd2,
    REG_FRAME_HEIGHT = 2'd3
  } reg_idx_t;

  // line buffer control from the stream control
  typedef struct packed {
    logic shift;  // one sample enters the window
    logic clr;    // frame restart, rewind the column pointer
  } lb_ctl_t;

  // 4-neighbour window around the centre pixel
  typedef struct packed {
    logic above;
    logic lft;
    logic ctr;
    logic rgt;
    logic below;
  } win_t;

  // frame border flags of the centre pixel
  typedef struct packed {
    logic top;
    logic bot;
    logic lft;
    logic rgt;
  } bnd_t;

endpackage

`default_nettype wire

[src/bnc_window.sv]
`default_nettype none

module bnc_window import bnc_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire lb_ctl_t                          ctl,
  input  wire logic [$clog2(MAX_WIDTH+1)-1:0]   w_eff,
  input  wire logic                             pix,
  output win_t                                  win
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // two line buffers, each delays its input by one frame line
  logic lb0_mem [MAX_WIDTH];
  logic lb1_mem [MAX_WIDTH];

  logic [AW-1:0] wptr_r, wptr_nxt;
  logic          q0_r;     // newest pixel minus one line
  logic          q1_r;     // newest pixel minus two lines and one
  logic          ctr_r;
  logic          lft_r;
  logic          last_r;   // newest pixel
  logic          below_r;  // newest pixel minus one

  // column pointer wraps at the active line width
  always_comb begin
    if ((WW'(wptr_r) + WW'(1)) >= w_eff) begin
      wptr_nxt = '0;
    end else begin
      wptr_nxt = wptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
    end else if (ctl.clr) begin
      wptr_r <= '0;
    end else if (ctl.shift) begin
      wptr_r <= wptr_nxt;
    end
  end

  // line buffer reads before writes at the same column
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q0_r             <= lb0_mem[wptr_r];
      lb0_mem[wptr_r]  <= pix;
      q1_r             <= lb1_mem[wptr_r];
      lb1_mem[wptr_r]  <= q0_r;
    end
  end

  // short taps around the centre
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      ctr_r   <= q0_r;
      lft_r   <= ctr_r;
      last_r  <= pix;
      below_r <= last_r;
    end
  end

  assign win.above = q1_r;
  assign win.lft   = lft_r;
  assign win.ctr   = ctr_r;
  assign win.rgt   = q0_r;
  assign win.below = below_r;

endmodule

`default_nettype wire

[src/binary_neighbour_count_filter_unit.sv]
`default_nettype none

// Binary 4-neighbour count filter. Pixels of a binary frame enter in raster order, one per
// transfer, and each output pixel is the centre of a window built from two line buffers, so it
// depends only on unfiltered neighbours. Open mode turns a 0 into 1 when fewer than threshold of
// its neighbours are 0; close mode turns a 1 into 0 when fewer than threshold are 1; neighbours
// outside the frame count as matching. Throughput is one pixel per clock while out_ready does not
// stall the output; a pixel passes the input stage, the window stage and the output register,
// and the output for a position appears with the input one line plus one pixel later, so
// frame_width + 1 drain items flush the frame tail.
// The rate is set by the two line buffer memories (MAX_WIDTH entries of one bit each), each
// taking one read and one write per pixel. Writing frame_width or frame_height restarts the
// frame; a pixel after the last output of a frame starts the next frame. No clearing pass runs
// after reset.
module binary_neighbour_count_filter_unit import bnc_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input stream
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic              in_pixel_in,
  input  wire logic              in_drain,
  // result stream
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_pixel_out,
  output logic                   out_end_of_frame,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  localparam int WW   = $clog2(MAX_WIDTH + 1);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int TW   = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int CNTW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

  // clamp a raw frame size to the supported range
  function automatic logic [WW-1:0] eff_w(input logic [10:0] raw);
    logic [WW-1:0] res;
    if (raw == 11'd0) begin
      res = WW'(1);
    end else if (32'(raw) > 32'(MAX_WIDTH)) begin
      res = WW'(MAX_WIDTH);
    end else begin
      res = WW'(raw);
    end
    return res;
  endfunction

  function automatic logic [HW-1:0] eff_h(input logic [10:0] raw);
    logic [HW-1:0] res;
    if (raw == 11'd0) begin
      res = HW'(1);
    end else if (32'(raw) > 32'(MAX_HEIGHT)) begin
      res = HW'(MAX_HEIGHT);
    end else begin
      res = HW'(raw);
    end
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic          mode_close_r;
  logic [2:0]    threshold_r;
  logic [10:0]   frame_width_r;
  logic [10:0]   frame_height_r;
  logic [WW-1:0] w_eff_r;
  logic [HW-1:0] h_eff_r;
  logic [TW-1:0] total_r;

  reg_idx_t      reg_idx;
  logic          cfg_wr;
  logic          restart_cfg;
  logic [WW-1:0] w_new;
  logic [HW-1:0] h_new;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[3:2]);
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign w_new   = eff_w(pwdata[10:0]);
  assign h_new   = eff_h(pwdata[10:0]);
  assign restart_cfg = cfg_wr &
                       ((reg_idx == REG_FRAME_WIDTH) || (reg_idx == REG_FRAME_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_close_r   <= RST_MODE_CLOSE;
      threshold_r    <= RST_THRESHOLD;
      frame_width_r  <= RST_FRAME;
      frame_height_r <= RST_FRAME;
      w_eff_r        <= eff_w(RST_FRAME);
      h_eff_r        <= eff_h(RST_FRAME);
      total_r        <= TW'(eff_w(RST_FRAME)) * TW'(eff_h(RST_FRAME));
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE_CLOSE: begin
          mode_close_r <= pwdata[0];
        end
        REG_THRESHOLD: begin
          threshold_r <= pwdata[2:0];
        end
        REG_FRAME_WIDTH: begin
          frame_width_r <= pwdata[10:0];
          w_eff_r       <= w_new;
          total_r       <= TW'(w_new) * TW'(h_eff_r);
        end
        REG_FRAME_HEIGHT: begin
          frame_height_r <= pwdata[10:0];
          h_eff_r        <= h_new;
          total_r        <= TW'(w_eff_r) * TW'(h_new);
        end
        default: begin
        end
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      REG_MODE_CLOSE:   prdata = DATA_W'(mode_close_r);
      REG_THRESHOLD:    prdata = DATA_W'(threshold_r);
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height_r);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline handshake
  // ---------------------------------------------------------------------------
  logic s1_vld_r, s2_vld_r, out_vld_r;
  logic out_free, s2_free, s1_free;
  logic s1_go, s2_go, in_fire;

  assign out_free = !out_vld_r || out_ready;
  assign s2_go    = s2_vld_r & out_free;
  assign s2_free  = !s2_vld_r || out_free;
  assign s1_go    = s1_vld_r & s2_free;
  assign s1_free  = !s1_vld_r || s2_free;
  assign in_ready = s1_free;
  assign in_fire  = in_valid & in_ready;

  // ---------------------------------------------------------------------------
  // frame counters, decided at the input transfer
  // ---------------------------------------------------------------------------
  logic [CNTW-1:0] in_cnt_r;
  logic [TW-1:0]   em_cnt_r;
  logic [WW-1:0]   col_r;
  logic [HW-1:0]   row_r;
  logic            done_r;   // last output of the frame issued at the input

  logic [CNTW-1:0] in_base;
  logic [TW-1:0]   em_base;
  logic [WW-1:0]   col_base, col_inc;
  logic [HW-1:0]   row_base, row_inc;
  logic            in_full, cnt_item, emit, eof;
  bnd_t            bnd;

  // a finished frame restarts on its next pixel
  always_comb begin
    if (done_r) begin
      in_base  = '0;
      em_base  = '0;
      col_base = '0;
      row_base = '0;
    end else begin
      in_base  = in_cnt_r;
      em_base  = em_cnt_r;
      col_base = col_r;
      row_base = row_r;
    end
    col_inc  = col_base + WW'(1);
    row_inc  = row_base + HW'(1);
    in_full  = !done_r && (in_cnt_r >= CNTW'(total_r));
    // a drain only counts once all pixels are in, a late pixel acts as a drain
    cnt_item = !in_drain || in_full;
    emit     = cnt_item && (in_base > CNTW'(w_eff_r));
    eof      = (em_base + TW'(1)) == total_r;
    bnd.top  = (row_base == '0);
    bnd.bot  = (row_inc >= h_eff_r);
    bnd.lft  = (col_base == '0);
    bnd.rgt  = (col_inc >= w_eff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_cnt_r <= '0;
      em_cnt_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      done_r   <= 1'b0;
    end else if (restart_cfg) begin
      in_cnt_r <= '0;
      em_cnt_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
      done_r   <= 1'b0;
    end else if (in_fire && cnt_item) begin
      in_cnt_r <= in_base + CNTW'(1);
      if (emit) begin
        em_cnt_r <= em_base + TW'(1);
        done_r   <= eof;
        if (col_inc >= w_eff_r) begin
          col_r <= '0;
          row_r <= row_inc;
        end else begin
          col_r <= col_inc;
          row_r <= row_base;
        end
      end else begin
        em_cnt_r <= em_base;
        done_r   <= 1'b0;
        col_r    <= col_base;
        row_r    <= row_base;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: accepted sample
  // ---------------------------------------------------------------------------
  logic s1_pix_r, s1_emit_r, s1_eof_r;
  bnd_t s1_bnd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_free) begin
      s1_vld_r <= in_fire & cnt_item;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_pix_r  <= in_full ? 1'b0 : in_pixel_in;
      s1_emit_r <= emit;
      s1_eof_r  <= eof;
      s1_bnd_r  <= bnd;
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: window from the line buffers
  // ---------------------------------------------------------------------------
  lb_ctl_t lb_ctl;
  win_t    win;
  logic    s2_eof_r;
  bnd_t    s2_bnd_r;

  assign lb_ctl.shift = s1_go;
  assign lb_ctl.clr   = restart_cfg;

  bnc_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_window (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (lb_ctl),
    .w_eff (w_eff_r),
    .pix   (s1_pix_r),
    .win   (win)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_free) begin
      s2_vld_r <= s1_go & s1_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_eof_r <= s1_eof_r;
      s2_bnd_r <= s1_bnd_r;
    end
  end

  // ---------------------------------------------------------------------------
  // neighbour count rule
  // ---------------------------------------------------------------------------
  logic       want;
  logic [2:0] match_cnt;
  logic       result;

  always_comb begin
    want      = mode_close_r;
    match_cnt = 3'(s2_bnd_r.top | (win.above == want)) +
                3'(s2_bnd_r.bot | (win.below == want)) +
                3'(s2_bnd_r.lft | (win.lft   == want)) +
                3'(s2_bnd_r.rgt | (win.rgt   == want));
    if ((win.ctr == want) && (match_cnt < threshold_r)) begin
      result = ~want;
    end else begin
      result = win.ctr;
    end
  end

  // ---------------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------------
  logic out_pix_r, out_eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      out_pix_r <= result;
      out_eof_r <= s2_eof_r;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_pixel_out    = out_pix_r;
  assign out_end_of_frame = out_eof_r;

endmodule

`default_nettype wire
